@@ src/rlsharp_pkg.sv @@
// Package: shared constants and types for the red-channel 3x3 sharpening filter.
`default_nettype none
package rlsharp_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FRM_W_W    = 13;
  localparam int unsigned FRM_H_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  // width compare is done one bit wider than the register so MAX_WIDTH fits
  localparam int unsigned WCMP_W     = FRM_W_W + 1;
  // sharpen sum: 5*255 down to -4*255 fits in 12 bits signed
  localparam int unsigned SUM_W      = 12;

  localparam logic [FRM_W_W-1:0] FRM_W_RST = FRM_W_W'(640);
  localparam logic [FRM_H_W-1:0] FRM_H_RST = FRM_H_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;

endpackage
`default_nettype wire

@@ src/red_laplacian_sharpen_3x3_top.sv @@
// Top level: red-channel 3x3 Laplacian sharpener with two line stores in one RAM.
//
// Pixels enter in raster order on the in_valid_i/in_ready_o channel, one beat
// per pixel; green and blue are dropped. Frame size comes from the config port
// (frame_width, frame_height), written while the block is idle.
// For every interior pixel one beat leaves on out_valid_o/out_ready_i:
// 5*centre minus the up, down, left and right neighbours, clamped to 0..255, with
// last_pixel_o set on the last interior pixel of the frame. The result for
// pixel (r-1,c-1) is produced by input pixel (r,c); border pixels give no beat.
// A result passes through the stage-1 registers and then the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// single line-store RAM, which can read one entry and write one entry in the
// same cycle; a same-entry read issued together with a write is forwarded.
// Receiver stall: the output register holds its beat; one more pixel can be
// accepted, and in_ready_o drops only when that pixel also has a result.
// Reset: positions, window and handshake state clear; the line stores are
// not cleared, and the first two rows of each frame refill them.
`default_nettype none
module red_laplacian_sharpen_3x3_top #(
  parameter int unsigned MAX_WIDTH = rlsharp_pkg::MAX_WIDTH_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_we_i,
  input  wire  [rlsharp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [rlsharp_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire                                      in_valid_i,
  output logic                                     in_ready_o,
  input  wire  [rlsharp_pkg::PIX_W-1:0]            red_in_i,
  input  wire  [rlsharp_pkg::PIX_W-1:0]            green_in_i,
  input  wire  [rlsharp_pkg::PIX_W-1:0]            blue_in_i,
  output logic                                     out_valid_o,
  input  wire                                      out_ready_i,
  output logic [rlsharp_pkg::PIX_W-1:0]            red_out_o,
  output logic                                     last_pixel_o
);

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned PW     = rlsharp_pkg::PIX_W;
  localparam int unsigned WW     = rlsharp_pkg::WCMP_W;
  localparam int unsigned HW     = rlsharp_pkg::FRM_H_W;
  localparam int unsigned SW     = rlsharp_pkg::SUM_W;
  localparam logic [WW-1:0] WMAX = WW'(MAX_WIDTH);

  // configuration
  logic [rlsharp_pkg::FRM_W_W-1:0] cfg_width_q;
  logic [HW-1:0]                   cfg_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= rlsharp_pkg::FRM_W_RST;
      cfg_height_q <= rlsharp_pkg::FRM_H_RST;
    end else if (cfg_we_i) begin
      unique case (rlsharp_pkg::cfg_reg_e'(cfg_idx_i))
        rlsharp_pkg::REG_FRAME_WIDTH:
          cfg_width_q  <= cfg_wdata_i[rlsharp_pkg::FRM_W_W-1:0];
        rlsharp_pkg::REG_FRAME_HEIGHT:
          cfg_height_q <= cfg_wdata_i[HW-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  logic [HW:0]   h_eff;

  always_comb begin
    w_eff = {1'b0, cfg_width_q};
    if (w_eff == '0) begin
      w_eff = WW'(1);
    end else if (w_eff > WMAX) begin
      w_eff = WMAX;
    end
    h_eff = {1'b0, cfg_height_q};
    if (h_eff == '0) begin
      h_eff = (HW+1)'(1);
    end
  end

  // raster position
  logic [AW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic          end_row, end_frame, emit;
  logic          in_acc;

  assign in_acc    = in_valid_i && in_ready_o;
  assign end_row   = ((WW'(col_q) + WW'(1)) >= w_eff);
  assign end_frame = end_row && (((HW+1)'(row_q) + (HW+1)'(1)) >= h_eff);
  assign emit      = (row_q >= HW'(2)) && (col_q >= AW'(2));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_frame ? '0 : row_q + HW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores: entry = {two rows above, one row above}
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] mem_rdata_q;
  logic [2*PW-1:0] mem_wdata;
  logic            mem_we;

  // stage 1: line-store data back, window update
  logic          p1_valid_q;
  logic [PW-1:0] p1_red_q;
  logic [AW-1:0] p1_col_q;
  logic          p1_emit_q;
  logic          p1_last_q;
  logic          p1_fwd_q;
  logic [2*PW-1:0] fwd_data_q;
  logic          p1_adv;
  logic          out_valid_q;

  assign p1_adv     = p1_valid_q && (!p1_emit_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !p1_valid_q || p1_adv;
  assign mem_we     = p1_adv;

  logic [2*PW-1:0] line_rd;
  logic [PW-1:0]   above_rd, two_above_rd;

  assign line_rd      = p1_fwd_q ? fwd_data_q : mem_rdata_q;
  assign two_above_rd = line_rd[2*PW-1:PW];
  assign above_rd     = line_rd[PW-1:0];
  assign mem_wdata    = {above_rd, p1_red_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[p1_col_q] <= mem_wdata;
    end
    if (in_acc) begin
      mem_rdata_q <= line_mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      p1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_red_q   <= red_in_i;
      p1_col_q   <= col_q;
      p1_emit_q  <= emit;
      p1_last_q  <= end_frame;
      // the write at this edge is not yet visible to the read issued with it
      p1_fwd_q   <= p1_adv && (p1_col_q == col_q);
      fwd_data_q <= mem_wdata;
    end
  end

  // window: last column taken in (top/mid/bot) and the mid pixel of the column before it
  logic [PW-1:0] win_top_q, win_mid_q, win_bot_q, win_ctr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_top_q <= '0;
      win_mid_q <= '0;
      win_bot_q <= '0;
      win_ctr_q <= '0;
    end else if (p1_adv) begin
      win_ctr_q <= win_mid_q;
      win_top_q <= two_above_rd;
      win_mid_q <= above_rd;
      win_bot_q <= p1_red_q;
    end
  end

  // 5*centre - up - down - left - right, centre before the shift is win_mid_q
  logic signed [SW-1:0] sum;
  logic [PW-1:0]        sharp;

  always_comb begin
    sum = SW'({win_mid_q, 2'b00}) + SW'(win_mid_q)
        - SW'(win_top_q) - SW'(win_bot_q) - SW'(win_ctr_q) - SW'(above_rd);
    if (sum < 0) begin
      sharp = '0;
    end else if (sum > SW'(255)) begin
      sharp = '1;
    end else begin
      sharp = sum[PW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p1_adv && p1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv && p1_emit_q) begin
      red_out_o    <= sharp;
      last_pixel_o <= p1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ src/rlsharp_checker.sv @@
// Checker: port-level assertions for the sharpener top level, with its bind.
`default_nettype none
module rlsharp_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_o,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire [rlsharp_pkg::PIX_W-1:0]     red_out_o,
  input wire                              last_pixel_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(red_out_o) && $stable(last_pixel_o))
    else $error("output beat changed under stall");

  // input stalls only under output backpressure
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a new output beat needs an input beat that passed through stage 1 before it
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output beat without a causing input beat");

  // nothing is pending coming out of reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind red_laplacian_sharpen_3x3_top rlsharp_checker u_rlsharp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .red_out_o    (red_out_o),
  .last_pixel_o (last_pixel_o)
);
`default_nettype wire
